>>> hdl/grpt_pkg.sv
// Shared widths, types and register codes for the gaze ray point transform.
// No dependencies; every other file imports this package.
package grpt_pkg;

    // Coordinate width of the input and result words
    localparam int CW   = 32;
    // Direction difference and magnitude width
    localparam int MW   = CW + 1;
    // Width of a leading-one position within MW
    localparam int SHW  = $clog2(MW);
    // Normalized magnitude: top component lies in [2^29, 2^30)
    localparam int NW   = 30;
    // Square and sum of squares
    localparam int SQW  = 2 * NW + 2;
    // Root width, also the number of root and divide steps
    localparam int RW   = 31;
    // Unit vector component, Q1.30
    localparam int UW   = RW;
    // Distance register width
    localparam int DW   = 32;
    // Offset along the ray
    localparam int OW   = 34;
    // Gaze point before the transform, signed
    localparam int PW   = ((CW > OW) ? CW : OW) + 1;
    // Transform coefficient width
    localparam int CFW  = 16;
    // Transform accumulator
    localparam int ACCW = PW + CFW + 2;
    // Accumulator after dropping 13 fraction bits
    localparam int RSW  = ACCW - 13;

    // APB register map
    localparam int AW   = 5;
    localparam logic [1:0] REG_ROW_X = 2'd0;
    localparam logic [1:0] REG_ROW_Y = 2'd1;
    localparam logic [1:0] REG_ROW_Z = 2'd2;
    localparam logic [1:0] REG_DIST  = 2'd3;

    localparam logic [63:0] ROW_X_RST = 64'd8192;
    localparam logic [63:0] ROW_Y_RST = 64'd8192 << 16;
    localparam logic [63:0] ROW_Z_RST = 64'd8192 << 32;
    localparam logic [DW-1:0] DIST_RST = 32'd65536000;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [2:0][63:0] row;
        logic [DW-1:0]    gaze_dist;
    } cfg_t;

    // Per-word sideband carried alongside the root and divide pipes
    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0]         neg;
        logic [2:0][NW-1:0] mag;
        logic               zero;
    } side_t;

endpackage

>>> hdl/grpt_cfg.sv
// APB register file for the transform rows and the gaze distance.
// Depends on grpt_pkg.
module grpt_cfg
    import grpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output cfg_t          cfg
);

    logic [2:0][63:0] row_reg;
    logic [DW-1:0]    dist_reg;
    logic             wr_w;
    logic [1:0]       idx_w;

    assign pready = 1'b1;
    assign wr_w   = psel && penable && pwrite;
    assign idx_w  = paddr[4:3];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_X_RST;
            row_reg[1] <= ROW_Y_RST;
            row_reg[2] <= ROW_Z_RST;
            dist_reg   <= DIST_RST;
        end
        else if (wr_w)
        begin
            case (idx_w)
                REG_ROW_X: row_reg[0] <= pwdata;
                REG_ROW_Y: row_reg[1] <= pwdata;
                REG_ROW_Z: row_reg[2] <= pwdata;
                REG_DIST:  dist_reg   <= pwdata[DW-1:0];
                default:   ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx_w)
            REG_ROW_X: prdata = row_reg[0];
            REG_ROW_Y: prdata = row_reg[1];
            REG_ROW_Z: prdata = row_reg[2];
            REG_DIST:  prdata = {{(64-DW){1'b0}}, dist_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.row       = row_reg;
    assign cfg.gaze_dist = dist_reg;

endmodule

>>> hdl/grpt_front.sv
// Front end: direction, magnitude, normalizing shift, squares, sum of squares.
// Four register stages. Depends on grpt_pkg.
module grpt_front
    import grpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_in,
    input  logic [2:0][CW-1:0] st,
    input  logic [2:0][CW-1:0] ed,
    output logic               v_out,
    output side_t              side_out,
    output logic [SQW-1:0]     n_out
);

    // stage 1
    logic                     v1_reg;
    logic [2:0][CW-1:0]       s1_reg;
    logic [2:0]               neg1_reg, neg1_next;
    logic [2:0][MW-1:0]       mag1_reg, mag1_next;
    logic [MW-1:0]            max1_reg, max1_next;
    logic signed [MW-1:0]     d_w [3];
    // stage 2
    logic                     v2_reg;
    side_t                    side2_reg, side2_next;
    logic [SHW-1:0]           lead_w;
    // stage 3
    logic                     v3_reg;
    side_t                    side3_reg;
    logic [2:0][2*NW-1:0]     sq3_reg, sq3_next;
    // stage 4
    logic                     v4_reg;
    side_t                    side4_reg;
    logic [SQW-1:0]           n4_reg, n4_next;

    // Direction and magnitude
    always_comb
    begin
        max1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_w[i] = $signed({ed[i][CW-1], ed[i]}) - $signed({st[i][CW-1], st[i]});
            neg1_next[i] = d_w[i][MW-1];
            mag1_next[i] = neg1_next[i] ? MW'(-d_w[i]) : MW'(d_w[i]);
            if (mag1_next[i] > max1_next)
                max1_next = mag1_next[i];
        end
    end

    // Leading one of the largest component, then shift all three alike
    always_comb
    begin
        lead_w = '0;
        for (int b = 0; b < MW; b++)
            if (max1_reg[b])
                lead_w = SHW'(b);
        side2_next.s    = s1_reg;
        side2_next.neg  = neg1_reg;
        side2_next.zero = (max1_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (lead_w >= SHW'(NW - 1))
                side2_next.mag[i] = NW'(mag1_reg[i] >> (lead_w - SHW'(NW - 1)));
            else
                side2_next.mag[i] = NW'(mag1_reg[i] << (SHW'(NW - 1) - lead_w));
        end
    end

    // Squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq3_next[i] = side2_reg.mag[i] * side2_reg.mag[i];
    end

    // Sum of squares
    assign n4_next = SQW'(sq3_reg[0]) + SQW'(sq3_reg[1]) + SQW'(sq3_reg[2]);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= st;
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            max1_reg  <= max1_next;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sq3_reg   <= sq3_next;
            side4_reg <= side3_reg;
            n4_reg    <= n4_next;
        end
    end

    assign v_out    = v4_reg;
    assign side_out = side4_reg;
    assign n_out    = n4_reg;

endmodule

>>> hdl/grpt_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on grpt_pkg.
module grpt_isqrt
    import grpt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  side_t          side_in,
    input  logic [SQW-1:0] n_in,
    output logic           v_out,
    output side_t          side_out,
    output logic [RW-1:0]  r_out
);

    logic           v_reg    [RW];
    side_t          side_reg [RW];
    logic [SQW-1:0] n_reg    [RW];
    logic [SQW:0]   res_reg  [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam logic [SQW:0] BIT = (SQW + 1)'(1) << (2 * (RW - 1 - j));
        logic           v_w;
        side_t          side_w;
        logic [SQW-1:0] n_w, n_next;
        logic [SQW:0]   res_w, res_next, trial_w;

        if (j == 0)
        begin : g_first
            assign v_w    = v_in;
            assign side_w = side_in;
            assign n_w    = n_in;
            assign res_w  = '0;
        end
        else
        begin : g_rest
            assign v_w    = v_reg[j-1];
            assign side_w = side_reg[j-1];
            assign n_w    = n_reg[j-1];
            assign res_w  = res_reg[j-1];
        end

        // One root digit
        always_comb
        begin
            trial_w = res_w + BIT;
            if ({1'b0, n_w} >= trial_w)
            begin
                n_next   = SQW'({1'b0, n_w} - trial_w);
                res_next = (res_w >> 1) + BIT;
            end
            else
            begin
                n_next   = n_w;
                res_next = res_w >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_w;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_w;
                n_reg[j]    <= n_next;
                res_reg[j]  <= res_next;
            end
        end
    end

    assign v_out    = v_reg[RW-1];
    assign side_out = side_reg[RW-1];
    assign r_out    = res_reg[RW-1][RW-1:0];

endmodule

>>> hdl/grpt_div.sv
// Pipelined restoring divider, three lanes: unit vector = mag * 2^30 / root,
// rounded to nearest. One quotient bit per stage. Depends on grpt_pkg.
module grpt_div
    import grpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_in,
    input  side_t              side_in,
    input  logic [RW-1:0]      r_in,
    output logic               v_out,
    output side_t              side_out,
    output logic [2:0][UW-1:0] u_out
);

    logic               v_reg    [RW];
    side_t              side_reg [RW];
    logic [RW-1:0]      r_reg    [RW];
    logic [2:0][RW-1:0] rem_reg  [RW];
    logic [2:0][RW-1:0] low_reg  [RW];
    logic [2:0][UW-1:0] q_reg    [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        logic               v_w;
        side_t              side_w;
        logic [RW-1:0]      r_w;
        logic [2:0][RW-1:0] rem_w, low_w, rem_next, low_next;
        logic [2:0][UW-1:0] q_w, q_next;
        logic [RW:0]        t_w [3];

        if (j == 0)
        begin : g_first
            // Numerator is {mag, root/2}; its top part is below the root
            assign v_w    = v_in;
            assign side_w = side_in;
            assign r_w    = r_in;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_w[i] = RW'(side_in.mag[i] >> 1);
                assign low_w[i] = {side_in.mag[i][0], r_in[RW-1:1]};
                assign q_w[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign v_w    = v_reg[j-1];
            assign side_w = side_reg[j-1];
            assign r_w    = r_reg[j-1];
            assign rem_w  = rem_reg[j-1];
            assign low_w  = low_reg[j-1];
            assign q_w    = q_reg[j-1];
        end

        // One quotient bit per lane
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_w[i] = {rem_w[i], low_w[i][RW-1]};
                low_next[i] = low_w[i] << 1;
                if (t_w[i] >= {1'b0, r_w})
                begin
                    rem_next[i] = RW'(t_w[i] - {1'b0, r_w});
                    q_next[i]   = {q_w[i][UW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = t_w[i][RW-1:0];
                    q_next[i]   = {q_w[i][UW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_w;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_w;
                r_reg[j]    <= r_w;
                rem_reg[j]  <= rem_next;
                low_reg[j]  <= low_next;
                q_reg[j]    <= q_next;
            end
        end
    end

    assign v_out    = v_reg[RW-1];
    assign side_out = side_reg[RW-1];
    assign u_out    = q_reg[RW-1];

endmodule

>>> hdl/grpt_back.sv
// Back end: offset along the ray, gaze point, affine transform, rounding,
// saturation and the output register. Depends on grpt_pkg.
module grpt_back
    import grpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_in,
    input  side_t              side_in,
    input  logic [2:0][UW-1:0] u_in,
    input  cfg_t               cfg,
    output logic               v_out,
    output logic [2:0][CW-1:0] scene,
    output logic               zero_out,
    output logic               sat_out
);

    // stage A: u * distance
    logic                      va_reg;
    side_t                     sidea_reg;
    logic [2:0][UW+DW-1:0]     proda_reg, proda_next;
    // stage B: gaze point
    logic                      vb_reg;
    logic                      zerob_reg;
    logic [2:0][PW-1:0]        pb_reg, pb_next;
    logic [UW+DW:0]            rnd_w [3];
    logic [OW-1:0]             off_w [3];
    // stage C: coefficient products
    logic                      vc_reg;
    logic                      zeroc_reg;
    logic [2:0][2:0][PW+CFW-1:0] prodc_reg, prodc_next;
    // stage D: output
    logic                      vd_reg;
    logic                      zerod_reg;
    logic [2:0][CW-1:0]        scened_reg, scened_next;
    logic                      satd_reg, satd_next;
    logic signed [ACCW-1:0]    acc_w [3];
    logic signed [RSW-1:0]     rs_w  [3];

    // Offset products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            proda_next[i] = u_in[i] * cfg.gaze_dist;
    end

    // Round the offset and apply it to the start point
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_w[i] = {1'b0, proda_reg[i]} + ((UW + DW + 1)'(1) << 29);
            off_w[i] = rnd_w[i][UW+DW:30];
            if (sidea_reg.zero)
                pb_next[i] = PW'($signed(sidea_reg.s[i]));
            else if (sidea_reg.neg[i])
                pb_next[i] = PW'($signed(sidea_reg.s[i])) - PW'(off_w[i]);
            else
                pb_next[i] = PW'($signed(sidea_reg.s[i])) + PW'(off_w[i]);
        end
    end

    // Coefficient times point, each row and column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                prodc_next[r][c] = (PW + CFW)'($signed(cfg.row[r][16*c +: CFW])
                                   * $signed(pb_reg[c]));
    end

    // Sum, add translation, round half up, saturate
    always_comb
    begin
        satd_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            acc_w[r] = ACCW'($signed(prodc_reg[r][0])) + ACCW'($signed(prodc_reg[r][1]))
                     + ACCW'($signed(prodc_reg[r][2]))
                     + (ACCW'($signed(cfg.row[r][63:48])) <<< 25)
                     + ACCW'(4096);
            rs_w[r] = RSW'(acc_w[r] >>> 13);
            if ((rs_w[r][RSW-1:CW-1] == '0) || (rs_w[r][RSW-1:CW-1] == '1))
                scened_next[r] = rs_w[r][CW-1:0];
            else
            begin
                satd_next = 1'b1;
                scened_next[r] = rs_w[r][RSW-1] ? {1'b1, {(CW-1){1'b0}}}
                                                : {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sidea_reg  <= side_in;
            proda_reg  <= proda_next;
            zerob_reg  <= sidea_reg.zero;
            pb_reg     <= pb_next;
            zeroc_reg  <= zerob_reg;
            prodc_reg  <= prodc_next;
            zerod_reg  <= zeroc_reg;
            scened_reg <= scened_next;
            satd_reg   <= satd_next;
        end
    end

    assign v_out    = vd_reg;
    assign scene    = scened_reg;
    assign zero_out = zerod_reg;
    assign sat_out  = satd_reg;

endmodule

>>> hdl/gaze_ray_point_transform.sv
// Gaze ray point transform: takes one word per clock unless stalled, ray start
// and through point, and returns the gaze point at the configured distance
// mapped into scene space. The pipeline has 4 front stages, 31 root stages
// (one bit each), 31 divider stages (one quotient bit each) and 4 back stages
// ending in the output register. A stall on the output holds the whole pipeline.
// Depends on grpt_pkg, grpt_cfg, grpt_front, grpt_isqrt, grpt_div, grpt_back.
module gaze_ray_point_transform
    import grpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] start_x,
    input  logic signed [CW-1:0] start_y,
    input  logic signed [CW-1:0] start_z,
    input  logic signed [CW-1:0] end_x,
    input  logic signed [CW-1:0] end_y,
    input  logic signed [CW-1:0] end_z,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] scene_x,
    output logic signed [CW-1:0] scene_y,
    output logic signed [CW-1:0] scene_z,
    output logic                 zero_direction,
    output logic                 saturated
);

    cfg_t               cfg_w;
    logic               en_w;
    logic               vf_w, vs_w, vd_w;
    side_t              sidef_w, sides_w, sided_w;
    logic [SQW-1:0]     n_w;
    logic [RW-1:0]      r_w;
    logic [2:0][UW-1:0] u_w;
    logic [2:0][CW-1:0] scene_w;

    // Pipeline moves unless a finished word is waiting
    assign en_w     = !out_valid || out_ready;
    assign in_ready = en_w;

    grpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg_w)
    );

    grpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_w),
        .v_in     (in_valid),
        .st       ({start_z, start_y, start_x}),
        .ed       ({end_z, end_y, end_x}),
        .v_out    (vf_w),
        .side_out (sidef_w),
        .n_out    (n_w)
    );

    grpt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_w),
        .v_in     (vf_w),
        .side_in  (sidef_w),
        .n_in     (n_w),
        .v_out    (vs_w),
        .side_out (sides_w),
        .r_out    (r_w)
    );

    grpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_w),
        .v_in     (vs_w),
        .side_in  (sides_w),
        .r_in     (r_w),
        .v_out    (vd_w),
        .side_out (sided_w),
        .u_out    (u_w)
    );

    grpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_w),
        .v_in     (vd_w),
        .side_in  (sided_w),
        .u_in     (u_w),
        .cfg      (cfg_w),
        .v_out    (out_valid),
        .scene    (scene_w),
        .zero_out (zero_direction),
        .sat_out  (saturated)
    );

    assign scene_x = scene_w[0];
    assign scene_y = scene_w[1];
    assign scene_z = scene_w[2];

endmodule
